// ===== src/dit_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dit_pkg: shared types and codes for the disjoint interval tracker
// Transaction structs, status codes, cell operations and controller states.
// ----------------------------------------------------------------------------
package dit_pkg;

    // Input transaction kinds
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_DUMP = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_ADDED   = 3'd0;
    localparam logic [2:0] ST_COVERED = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_ENTRY   = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    typedef struct packed {
        logic        kind;
        logic [15:0] value;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] range_start;
        logic [15:0] range_end;
        logic        last;
    } result_t;

    // Operation broadcast to every cell in the update cycle
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SET_END,
        OP_SET_START,
        OP_BRIDGE,
        OP_INSERT
    } cell_op_t;

    // Per-cell compare results, seen by the controller and the neighbors
    typedef struct packed {
        logic le;          // occupied and start <= value
        logic prev;        // last cell with start <= value
        logic pos;         // first cell with start > value (insertion point)
        logic prev_cover;  // prev cell already covers the value
        logic prev_adj;    // prev cell ends just below the value
        logic next_adj;    // occupied pos cell starts just above the value
    } cell_flags_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD,
        S_DUMP
    } state_t;

endpackage
`default_nettype wire

// ===== src/disjoint_interval_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// disjoint_interval_tracker: sorted set of disjoint closed intervals
// Adds single values with merge/bridge and dumps the set in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item) takes add or dump transactions.
//   result channel (result_valid/result_ready/result) returns one status per
//   add, and one entry per stored interval (or one empty status) per dump,
//   with last set on the final result of each input transaction.
// Operation:
//   An add has a compare cycle where every cell of the chain
//   checks its interval against the value in parallel, then an update cycle
//   where all cells shift or rewrite at once. Result appears in the output
//   register at the end of the update cycle; a new add is taken in that same
//   update cycle.
//   A dump returns one entry per stored interval (one empty status when
//   empty), reading the chain through one selector on the dump index.
// Reset clears the state, interval count, dump index and result_valid;
//   cells and result data are not cleared. If result_ready stays low, the
//   update or dump step waits for a free output slot; no result is dropped.
// ----------------------------------------------------------------------------
module disjoint_interval_tracker #(
    parameter int MAX_INTERVALS = 32,
    parameter int VALUE_BITS    = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire dit_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output dit_pkg::result_t      result
);

    localparam int CW = $clog2(MAX_INTERVALS + 1);  // count width
    localparam int IW = $clog2(MAX_INTERVALS);      // cell index width

    dit_pkg::state_t      state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [IW-1:0]        dump_idx_reg, dump_idx_next;
    logic [VALUE_BITS-1:0] v_reg;
    logic                 result_valid_reg;
    dit_pkg::result_t     result_reg, result_next;
    logic                 load_result;

    logic                 accept;
    logic                 slot_free;
    logic                 cmp_en;
    dit_pkg::cell_op_t    cell_op;
    logic                 any_cover, any_jp, any_jn, table_full;
    logic                 dump_empty, dump_last, upd_done, dump_done;

    logic [VALUE_BITS+15:0] in_wide;
    logic [VALUE_BITS+15:0] lo_wide, hi_wide;
    logic [VALUE_BITS-1:0]  rd_lo, rd_hi;

    logic [VALUE_BITS-1:0] cell_lo [MAX_INTERVALS];
    logic [VALUE_BITS-1:0] cell_hi [MAX_INTERVALS];
    dit_pkg::cell_flags_t  cell_flags [MAX_INTERVALS];
    logic [MAX_INTERVALS-1:0] occ_vec, prev_vec, pos_vec;
    logic [MAX_INTERVALS-1:0] cover_vec, jp_vec, jn_vec;

    assign accept    = item_valid && item_ready;
    assign slot_free = !result_valid_reg || result_ready;

    // input value masked to the table width
    assign in_wide = {{VALUE_BITS{1'b0}}, item.value};

    always_ff @(posedge clk)
    begin
        if (accept)
            v_reg <= in_wide[VALUE_BITS-1:0];
    end

    // ------------------------------------------------------------------
    // cell chain
    // ------------------------------------------------------------------
    for (genvar k = 0; k < MAX_INTERVALS; k++)
    begin : g_cell
        logic                  left_le, right_le;
        logic [VALUE_BITS-1:0] left_lo, left_hi, right_lo, right_hi;

        assign occ_vec[k] = count_reg > CW'(k);

        if (k == 0)
        begin : g_first
            assign left_le = 1'b1;
            assign left_lo = v_reg;
            assign left_hi = v_reg;
        end
        else
        begin : g_mid_l
            assign left_le = cell_flags[k-1].le;
            assign left_lo = cell_lo[k-1];
            assign left_hi = cell_hi[k-1];
        end

        if (k == MAX_INTERVALS - 1)
        begin : g_last
            assign right_le = 1'b0;
            assign right_lo = v_reg;
            assign right_hi = v_reg;
        end
        else
        begin : g_mid_r
            assign right_le = cell_flags[k+1].le;
            assign right_lo = cell_lo[k+1];
            assign right_hi = cell_hi[k+1];
        end

        dit_cell #(
            .VALUE_BITS(VALUE_BITS)
        ) u_cell (
            .clk      (clk),
            .cmp_en   (cmp_en),
            .occ      (occ_vec[k]),
            .v        (v_reg),
            .op       (cell_op),
            .left_le  (left_le),
            .right_le (right_le),
            .left_lo  (left_lo),
            .left_hi  (left_hi),
            .right_lo (right_lo),
            .right_hi (right_hi),
            .lo       (cell_lo[k]),
            .hi       (cell_hi[k]),
            .flags    (cell_flags[k])
        );

        assign prev_vec[k]  = cell_flags[k].prev;
        assign pos_vec[k]   = cell_flags[k].pos;
        assign cover_vec[k] = cell_flags[k].prev_cover;
        assign jp_vec[k]    = cell_flags[k].prev_adj;
        assign jn_vec[k]    = cell_flags[k].next_adj;
    end

    // at most one prev and one pos cell, so plain ORs pick the decision
    assign any_cover  = |cover_vec;
    assign any_jp     = |jp_vec;
    assign any_jn     = |jn_vec;
    assign table_full = count_reg == CW'(MAX_INTERVALS);

    // dump read port
    assign rd_lo   = cell_lo[dump_idx_reg];
    assign rd_hi   = cell_hi[dump_idx_reg];
    assign lo_wide = {16'b0, rd_lo};
    assign hi_wide = {16'b0, rd_hi};

    assign dump_empty = count_reg == '0;
    assign dump_last  = (CW'(dump_idx_reg) + CW'(1)) == count_reg;
    assign upd_done   = (state_reg == dit_pkg::S_UPD) && slot_free;
    assign dump_done  = (state_reg == dit_pkg::S_DUMP) && slot_free && (dump_empty || dump_last);

    // ------------------------------------------------------------------
    // controller: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dit_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = (item.kind == dit_pkg::KIND_DUMP) ? dit_pkg::S_DUMP
                                                                   : dit_pkg::S_CMP;
            end
            dit_pkg::S_CMP:
                state_next = dit_pkg::S_UPD;
            dit_pkg::S_UPD, dit_pkg::S_DUMP:
            begin
                if (accept)
                    state_next = (item.kind == dit_pkg::KIND_DUMP) ? dit_pkg::S_DUMP
                                                                   : dit_pkg::S_CMP;
                else if (upd_done || dump_done)
                    state_next = dit_pkg::S_IDLE;
            end
            default:
                state_next = dit_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // controller: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        item_ready    = 1'b0;
        cmp_en        = 1'b0;
        cell_op       = dit_pkg::OP_HOLD;
        count_next    = count_reg;
        dump_idx_next = dump_idx_reg;
        load_result   = 1'b0;
        result_next   = result_reg;
        unique case (state_reg)
            dit_pkg::S_IDLE:
                item_ready = 1'b1;
            dit_pkg::S_CMP:
                cmp_en = 1'b1;
            dit_pkg::S_UPD:
            begin
                if (slot_free)
                begin
                    item_ready              = 1'b1;
                    load_result             = 1'b1;
                    result_next.range_start = '0;
                    result_next.range_end   = '0;
                    result_next.last        = 1'b1;
                    result_next.status      = dit_pkg::ST_ADDED;
                    priority if (any_cover)
                        result_next.status = dit_pkg::ST_COVERED;
                    else if (any_jp && any_jn)
                    begin
                        cell_op    = dit_pkg::OP_BRIDGE;
                        count_next = count_reg - CW'(1);
                    end
                    else if (any_jp)
                        cell_op = dit_pkg::OP_SET_END;
                    else if (any_jn)
                        cell_op = dit_pkg::OP_SET_START;
                    else if (table_full)
                        result_next.status = dit_pkg::ST_FULL;
                    else
                    begin
                        cell_op    = dit_pkg::OP_INSERT;
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            dit_pkg::S_DUMP:
            begin
                if (slot_free)
                begin
                    load_result = 1'b1;
                    if (dump_empty)
                    begin
                        item_ready              = 1'b1;
                        result_next.status      = dit_pkg::ST_EMPTY;
                        result_next.range_start = '0;
                        result_next.range_end   = '0;
                        result_next.last        = 1'b1;
                    end
                    else
                    begin
                        result_next.status      = dit_pkg::ST_ENTRY;
                        result_next.range_start = lo_wide[15:0];
                        result_next.range_end   = hi_wide[15:0];
                        result_next.last        = dump_last;
                        if (dump_last)
                        begin
                            item_ready    = 1'b1;
                            dump_idx_next = '0;
                        end
                        else
                            dump_idx_next = dump_idx_reg + IW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= dit_pkg::S_IDLE;
            count_reg        <= '0;
            dump_idx_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            dump_idx_reg <= dump_idx_next;
            if (load_result)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_INTERVALS))
        else $error("interval count above table size");

    a_count_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == dit_pkg::S_UPD))
        else $error("interval count changed outside an update cycle");

    a_one_prev: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dit_pkg::S_UPD) |-> $onehot0(prev_vec))
        else $error("more than one predecessor cell");

    a_one_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dit_pkg::S_UPD) |-> $onehot0(pos_vec))
        else $error("more than one insertion point");

endmodule
`default_nettype wire

// ===== src/dit_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dit_cell: one slot of the interval chain
// Holds one interval, compares it with the pending value and shifts with
// its neighbors on insert or bridge.
// ----------------------------------------------------------------------------
module dit_cell #(
    parameter int VALUE_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  cmp_en,
    input  wire logic                  occ,
    input  wire logic [VALUE_BITS-1:0] v,
    input  wire dit_pkg::cell_op_t     op,
    input  wire logic                  left_le,
    input  wire logic                  right_le,
    input  wire logic [VALUE_BITS-1:0] left_lo,
    input  wire logic [VALUE_BITS-1:0] left_hi,
    input  wire logic [VALUE_BITS-1:0] right_lo,
    input  wire logic [VALUE_BITS-1:0] right_hi,
    output logic [VALUE_BITS-1:0]      lo,
    output logic [VALUE_BITS-1:0]      hi,
    output dit_pkg::cell_flags_t       flags
);

    logic [VALUE_BITS-1:0] lo_reg, lo_next;
    logic [VALUE_BITS-1:0] hi_reg, hi_next;
    logic                  le_reg, cover_reg, adj_end_reg, adj_start_reg;
    logic                  is_prev, is_pos;

    // compare stage; one extra bit so the top value never wraps
    always_ff @(posedge clk)
    begin
        if (cmp_en)
        begin
            le_reg        <= occ && (lo_reg <= v);
            cover_reg     <= hi_reg >= v;
            adj_end_reg   <= ({1'b0, hi_reg} + 1'b1) == {1'b0, v};
            adj_start_reg <= {1'b0, lo_reg} == ({1'b0, v} + 1'b1);
        end
    end

    assign is_prev = le_reg && !right_le;
    assign is_pos  = !le_reg && left_le;

    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        unique case (op)
            dit_pkg::OP_HOLD:
            begin
            end
            dit_pkg::OP_SET_END:
            begin
                if (is_prev)
                    hi_next = v;
            end
            dit_pkg::OP_SET_START:
            begin
                if (is_pos)
                    lo_next = v;
            end
            dit_pkg::OP_BRIDGE:
            begin
                if (is_prev)
                    hi_next = right_hi;
                else if (!le_reg)
                begin
                    lo_next = right_lo;
                    hi_next = right_hi;
                end
            end
            dit_pkg::OP_INSERT:
            begin
                if (is_pos)
                begin
                    lo_next = v;
                    hi_next = v;
                end
                else if (!le_reg)
                begin
                    lo_next = left_lo;
                    hi_next = left_hi;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    assign lo               = lo_reg;
    assign hi               = hi_reg;
    assign flags.le         = le_reg;
    assign flags.prev       = is_prev;
    assign flags.pos        = is_pos;
    assign flags.prev_cover = is_prev && cover_reg;
    assign flags.prev_adj   = is_prev && adj_end_reg;
    assign flags.next_adj   = occ && is_pos && adj_start_reg;

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the disjoint interval tracker
// Drives add and dump transactions with random idle gaps on both sides. An
// in-bench interval set predicts each status or dump entry, and every result
// is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_IV         = 32;
    localparam int LONG_HOLD      = 60;    // receiver hold-off, in cycles
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all

    // Interval set predictor plus the queue of results still owed by the block
    class interval_scoreboard;
        logic [15:0]      lo_tab[MAX_IV];
        logic [15:0]      hi_tab[MAX_IV];
        int               n_used;
        dit_pkg::result_t owed[$];
        int               mismatches;
        int               n_compared;
        int               n_add, n_dump, n_added, n_covered, n_full, n_bridge;

        function new();
            n_used     = 0;
            mismatches = 0;
            n_compared = 0;
            n_add      = 0;
            n_dump     = 0;
            n_added    = 0;
            n_covered  = 0;
            n_full     = 0;
            n_bridge   = 0;
        endfunction

        // Queue one expected result at the tail
        function void owe(dit_pkg::result_t r);
            owed.insert(owed.size(), r);
        endfunction

        // Apply one add to the set, return its status
        function logic [2:0] add_value(logic [15:0] v);
            int pos;
            bit join_lo;
            bit join_hi;
            pos = 0;
            while (pos < n_used && lo_tab[pos] <= v)
                pos++;
            if (pos > 0 && hi_tab[pos-1] >= v)
                return dit_pkg::ST_COVERED;
            // 17-bit sums: the top value has no neighbor above it
            join_lo = (pos > 0) && ({1'b0, hi_tab[pos-1]} + 17'd1 == {1'b0, v});
            join_hi = (pos < n_used) && ({1'b0, lo_tab[pos]} == {1'b0, v} + 17'd1);
            if (join_lo && join_hi)
            begin
                n_bridge++;
                hi_tab[pos-1] = hi_tab[pos];
                for (int j = pos; j + 1 < n_used; j++)
                begin
                    lo_tab[j] = lo_tab[j+1];
                    hi_tab[j] = hi_tab[j+1];
                end
                n_used--;
                return dit_pkg::ST_ADDED;
            end
            if (join_lo)
            begin
                hi_tab[pos-1] = v;
                return dit_pkg::ST_ADDED;
            end
            if (join_hi)
            begin
                lo_tab[pos] = v;
                return dit_pkg::ST_ADDED;
            end
            if (n_used >= MAX_IV)
                return dit_pkg::ST_FULL;
            for (int j = n_used; j > pos; j--)
            begin
                lo_tab[j] = lo_tab[j-1];
                hi_tab[j] = hi_tab[j-1];
            end
            lo_tab[pos] = v;
            hi_tab[pos] = v;
            n_used++;
            return dit_pkg::ST_ADDED;
        endfunction

        // Called on every accepted input transaction
        function void note_item(dit_pkg::item_t it);
            dit_pkg::result_t r;
            r = '0;
            if (it.kind == dit_pkg::KIND_ADD)
            begin
                n_add++;
                r.status = add_value(it.value);
                r.last   = 1'b1;
                case (r.status)
                    dit_pkg::ST_ADDED:   n_added++;
                    dit_pkg::ST_COVERED: n_covered++;
                    default:             n_full++;
                endcase
                owe(r);
            end
            else
            begin
                n_dump++;
                if (n_used == 0)
                begin
                    r.status = dit_pkg::ST_EMPTY;
                    r.last   = 1'b1;
                    owe(r);
                end
                else
                begin
                    for (int k = 0; k < n_used; k++)
                    begin
                        r.status      = dit_pkg::ST_ENTRY;
                        r.range_start = lo_tab[k];
                        r.range_end   = hi_tab[k];
                        r.last        = (k == n_used - 1);
                        owe(r);
                    end
                end
            end
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] seen);
            if (seen !== want)
            begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, seen);
            end
        endfunction

        // Called on every accepted result transaction
        function void check_result(dit_pkg::result_t got);
            dit_pkg::result_t want;
            if (owed.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
                         $time, got.status, got.range_start, got.range_end, got.last);
                return;
            end
            want = owed.pop_front();
            n_compared++;
            check_field("status", 16'(want.status), 16'(got.status));
            check_field("range_start", want.range_start, got.range_start);
            check_field("range_end", want.range_end, got.range_end);
            check_field("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    dit_pkg::item_t   item         = '0;
    logic             item_ready;
    logic             result_valid;
    logic             result_ready = 1'b0;
    dit_pkg::result_t result;

    interval_scoreboard sb = new();

    // Idle-pattern state per side: runs of transactions with or without gaps
    int tx_run_left = 0;
    bit tx_idle_on  = 1'b0;
    int rx_run_left = 0;
    bit rx_idle_on  = 1'b0;
    bit hold_off_req = 1'b0;   // main sequence asks the receiver for a long stall

    int idle_cycles = 0;

    disjoint_interval_tracker #(
        .MAX_INTERVALS (MAX_IV),
        .VALUE_BITS    (16)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Gap before the next transaction: random during an idle run, none during a busy run
    function automatic int draw_gap(ref int run_left, ref bit idle_on);
        if (run_left == 0)
        begin
            run_left = $urandom_range(4, 16);
            idle_on  = ($urandom_range(0, 3) != 0);
        end
        run_left--;
        return idle_on ? int'($urandom_range(0, 3)) : 0;
    endfunction

    // Offer one transaction and hold it until the block takes it
    task automatic send_item(logic kind, logic [15:0] value);
        dit_pkg::item_t it;
        int             gap;
        it.kind  = kind;
        it.value = value;
        gap = draw_gap(tx_run_left, tx_idle_on);
        repeat (gap)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        sb.note_item(it);
    endtask

    // Sender goes quiet until every owed result has come back
    task automatic wait_drain();
        item_valid <= 1'b0;
        while (sb.owed.size() != 0)
            @(posedge clk);
    endtask

    task automatic take_result();
        int gap;
        if (hold_off_req)
        begin
            hold_off_req = 1'b0;
            gap = LONG_HOLD;
        end
        else
        begin
            gap = draw_gap(rx_run_left, rx_idle_on);
        end
        repeat (gap)
        begin
            result_ready <= 1'b0;
            @(posedge clk);
        end
        result_ready <= 1'b1;
        @(posedge clk);
        while (!result_valid)
            @(posedge clk);
        sb.check_result(result);
    endtask

    initial
    begin : result_sink
        wait (rst_n === 1'b1);
        forever
            take_result();
    end

    // Hang detection: no transaction on either channel for too long
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin : main_seq
        logic [15:0] base;
        logic [15:0] v;
        int          pick;
        int          idx;

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty dump, low and top values, joins both ways, bridges
        send_item(dit_pkg::KIND_DUMP, 16'hFFFF);
        send_item(dit_pkg::KIND_ADD, 16'h0000);
        send_item(dit_pkg::KIND_ADD, 16'h0000);     // already covered
        send_item(dit_pkg::KIND_ADD, 16'h0001);     // extends the interval below
        send_item(dit_pkg::KIND_ADD, 16'h0003);
        send_item(dit_pkg::KIND_ADD, 16'h0002);     // bridges [0,1] and [3,3]
        send_item(dit_pkg::KIND_DUMP, 16'h0000);
        send_item(dit_pkg::KIND_ADD, 16'hFFFF);     // top value, no upper neighbor
        send_item(dit_pkg::KIND_ADD, 16'hFFFE);     // extends the interval above
        send_item(dit_pkg::KIND_ADD, 16'hFFFD);
        send_item(dit_pkg::KIND_ADD, 16'h8000);
        send_item(dit_pkg::KIND_ADD, 16'h7FFF);
        send_item(dit_pkg::KIND_ADD, 16'h5555);
        send_item(dit_pkg::KIND_ADD, 16'hAAAA);
        send_item(dit_pkg::KIND_ADD, 16'hAAAC);
        send_item(dit_pkg::KIND_ADD, 16'hAAAB);     // bridge in the middle of the set
        send_item(dit_pkg::KIND_ADD, 16'h5555);
        send_item(dit_pkg::KIND_ADD, 16'hFFFF);
        send_item(dit_pkg::KIND_DUMP, 16'h5A5A);
        wait_drain();

        // Clustered adds in a narrow window: lots of joins, bridges, covers.
        // The receiver holds off early so the block backs up.
        hold_off_req = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            if (i % 10 == 0)
                base = ($urandom_range(0, 3) == 0) ? 16'hFFC0
                                                   : 16'($urandom_range(0, 16'hFF00));
            if ($urandom_range(0, 7) == 0)
                send_item(dit_pkg::KIND_DUMP, 16'($urandom));
            else
                send_item(dit_pkg::KIND_ADD, base + 16'($urandom_range(0, 63)));
        end
        wait_drain();

        // Fill the table with scattered values, then work it while full:
        // merges at interval edges, covered values, drops, and full dumps
        for (int i = 0; i < 60; i++)
        begin
            if (sb.n_used < MAX_IV && i < 40)
            begin
                send_item(dit_pkg::KIND_ADD, 16'($urandom));
            end
            else
            begin
                pick = $urandom_range(0, 5);
                idx  = (sb.n_used > 0) ? $urandom_range(0, sb.n_used - 1) : 0;
                if (pick == 5)
                    send_item(dit_pkg::KIND_DUMP, 16'($urandom));
                else if (sb.n_used == 0 || pick < 2)
                    send_item(dit_pkg::KIND_ADD, 16'($urandom));
                else if (pick == 2)
                    send_item(dit_pkg::KIND_ADD, sb.hi_tab[idx] + 16'd1);
                else if (pick == 3)
                    send_item(dit_pkg::KIND_ADD, sb.lo_tab[idx] - 16'd1);
                else
                begin
                    v = sb.lo_tab[idx];
                    if (sb.hi_tab[idx] != v)
                        v = v + 16'd1;
                    send_item(dit_pkg::KIND_ADD, v);
                end
            end
        end
        wait_drain();

        // Unstructured noise
        for (int i = 0; i < 10; i++)
            send_item(($urandom_range(0, 5) == 0) ? dit_pkg::KIND_DUMP : dit_pkg::KIND_ADD,
                      16'($urandom));
        send_item(dit_pkg::KIND_DUMP, 16'($urandom));

        wait_drain();
        repeat (10)
            @(posedge clk);

        $display("Covered %0d adds: %0d added, %0d covered, %0d dropped when full, %0d bridges",
                 sb.n_add, sb.n_added, sb.n_covered, sb.n_full, sb.n_bridge);
        $display("plus %0d dumps; %0d results compared, %0d mismatches",
                 sb.n_dump, sb.n_compared, sb.mismatches);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
